>>> design/assert_macros.svh
// Assertion macros shared by checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled in reset
`define CHK_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("check failed");
// Next-cycle implication
`define CHK_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("check failed");
`endif

>>> design/ifd_pkg.sv
// ----------------------------------------------------------------------------
// ifd_pkg: shared types and constants of the fall detector
// Register indexes, phase codes, test constants, controller command struct.
// ----------------------------------------------------------------------------
package ifd_pkg;
    localparam int CALIB_COUNT_DEF      = 100;
    localparam int FILTER_FRAC_BITS_DEF = 8;

    localparam logic [2:0] REG_FREEFALL = 3'd0;
    localparam logic [2:0] REG_IMPACT   = 3'd1;
    localparam logic [2:0] REG_ROTATE   = 3'd2;
    localparam logic [2:0] REG_FASTROT  = 3'd3;
    localparam logic [2:0] REG_SUSLIM   = 3'd4;
    localparam logic [2:0] REG_CONLIM   = 3'd5;
    localparam logic [2:0] REG_STILL    = 3'd6;
    localparam logic [2:0] REG_LIECOS   = 3'd7;

    localparam logic [2:0] PH_CAL = 3'd0;
    localparam logic [2:0] PH_MON = 3'd1;
    localparam logic [2:0] PH_SUS = 3'd2;
    localparam logic [2:0] PH_CON = 3'd3;
    localparam logic [2:0] PH_ALM = 3'd4;

    localparam logic [63:0] ONE_G = 64'd4096;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture sample
        logic filt;     // filter update
        logic sq;       // squares of sample and filtered gravity
        logic dot;      // dot product and reference norm
        logic tilt;     // dot square, norm product, cosine square
        logic tmul;     // cosine square times norm product, two halves
        logic tcmp;     // cosine compare
        logic judge;    // phase update
    } ifd_cmd_t;
endpackage

>>> design/ifd_ctrl.sv
// ----------------------------------------------------------------------------
// ifd_ctrl: sequencer of one sample
// Steps the datapath through load, filter, squares, dot, tilt steps and judge.
// ----------------------------------------------------------------------------
module ifd_ctrl
    import ifd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output ifd_cmd_t cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILT = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_DOT  = 3'd3;
    localparam logic [2:0] S_TILT = 3'd4;
    localparam logic [2:0] S_TMUL = 3'd5;
    localparam logic [2:0] S_TCMP = 3'd6;
    localparam logic [2:0] S_JDG  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;

    // result word waits in the output register while the next sample runs
    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_FILT;
                end
            end
            S_FILT:
            begin
                cmd.filt   = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = S_DOT;
            end
            S_DOT:
            begin
                cmd.dot    = 1'b1;
                state_next = S_TILT;
            end
            S_TILT:
            begin
                cmd.tilt   = 1'b1;
                state_next = S_TMUL;
            end
            S_TMUL:
            begin
                cmd.tmul   = 1'b1;
                state_next = S_TCMP;
            end
            S_TCMP:
            begin
                cmd.tcmp   = 1'b1;
                state_next = S_JDG;
            end
            S_JDG:
            begin
                if (!(ov_reg && out_stall))
                begin
                    cmd.judge  = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

>>> design/ifd_datapath.sv
// ----------------------------------------------------------------------------
// ifd_datapath: filter, squares, tilt test and phase logic
// Runs one step per command from the sequencer; holds all detector state.
// ----------------------------------------------------------------------------
module ifd_datapath
    import ifd_pkg::*;
#(
    parameter int CALIB_COUNT      = CALIB_COUNT_DEF,
    parameter int FILTER_FRAC_BITS = FILTER_FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ifd_cmd_t           cmd,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    input  logic signed [15:0] gyro_z,
    input  logic               key_press,
    input  logic [14:0]        freefall_level,
    input  logic [14:0]        impact_level,
    input  logic [14:0]        rotate_level,
    input  logic [14:0]        fast_rotate_level,
    input  logic [15:0]        suspect_limit,
    input  logic [15:0]        confirm_limit,
    input  logic [15:0]        still_needed,
    input  logic [14:0]        lie_cosine,
    output logic [2:0]         fall_state,
    output logic               alarm_active,
    output logic               fall_report,
    output logic               alarm_cleared
);
    localparam int FW = 16 + FILTER_FRAC_BITS + 1;
    localparam int CW = $clog2(CALIB_COUNT + 1);
    // reciprocal of the calibration count, exact for sums below 2^24
    localparam int          CS = 24 + $clog2(CALIB_COUNT);
    localparam logic [63:0] CM = ((64'd1 << CS) + 64'(CALIB_COUNT) - 64'd1)
                                 / 64'(CALIB_COUNT);

    // sample
    logic signed [15:0] a_reg [3];
    logic signed [15:0] w_reg [3];
    logic               key_reg;
    // state
    logic [2:0]         phase_reg;
    logic signed [FW-1:0] fg_reg [3];
    logic               loaded_reg;
    logic signed [15:0] ref_reg [3];
    logic signed [23:0] csum_reg [3];
    logic [CW-1:0]      ccnt_reg;
    logic [15:0]        ticks_reg, still_reg;
    logic               imp_reg, rot_reg, rep_reg;
    // intermediates
    logic [33:0]        acc2_reg, gyr2_reg, lp2_reg, nb2_reg;
    logic signed [35:0] dot_reg;
    logic [63:0]        sqd_reg, prod_reg;
    logic [29:0]        cc_reg;
    logic [61:0]        rhi_reg, rlo_reg;
    logic               tilt_reg;
    // outputs
    logic [2:0]         fs_reg;
    logic               al_reg, rp_reg, cl_reg;

    assign fall_state    = fs_reg;
    assign alarm_active  = al_reg;
    assign fall_report   = rp_reg;
    assign alarm_cleared = cl_reg;

    // filtered gravity floored to 1/4096 g
    logic signed [15:0] c [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            c[i] = 16'(fg_reg[i] >>> FILTER_FRAC_BITS);
    end

    // filter update
    logic signed [FW-1:0] fg_new [3];
    always_comb
    begin
        logic signed [FW+1:0] d;
        logic signed [FW+7:0] m;
        for (int i = 0; i < 3; i++)
        begin
            m = '0;
            d = (FW+2)'($signed(a_reg[i])) <<< FILTER_FRAC_BITS;
            if (!loaded_reg)
                fg_new[i] = FW'(d);
            else
            begin
                d = d - (FW+2)'(fg_reg[i]);
                m = (FW+8)'(d) * (FW+8)'(38);
                fg_new[i] = fg_reg[i] + FW'(m >>> 8);
            end
        end
    end

    function automatic logic [33:0] sq3(input logic signed [15:0] x,
                                        input logic signed [15:0] y,
                                        input logic signed [15:0] z);
        logic signed [31:0] px, py, pz;
        px = x * x;
        py = y * y;
        pz = z * z;
        return 34'($unsigned(px)) + 34'($unsigned(py)) + 34'($unsigned(pz));
    endfunction

    function automatic logic near_g(input logic [33:0] m2, input logic [63:0] tol);
        logic [63:0] lo, hi, s;
        lo = (64'd100 - tol) * ONE_G;
        hi = (64'd100 + tol) * ONE_G;
        s  = 64'(m2) * 64'd10000;
        return (s > lo * lo) && (s < hi * hi);
    endfunction

    // calibration mean, truncated toward zero
    function automatic logic signed [15:0] calib_mean(input logic signed [23:0] s);
        logic [23:0] mag;
        logic [63:0] q;
        mag = s[23] ? 24'(-s) : 24'(s);
        q   = (64'(mag) * CM) >> CS;
        return s[23] ? -16'(q) : 16'(q);
    endfunction

    // tilt compare: (dot*32768)^2 < cos^2 * na2 * nb2
    logic tilt_c;
    always_comb
    begin
        logic [93:0] lhs, rhs;
        lhs = {sqd_reg, 30'd0};
        rhs = {rhi_reg, 32'd0} + 94'(rlo_reg);
        if ((64'(lp2_reg) * 64'd1000000 < 64'd16777216)
            || (64'(nb2_reg) * 64'd1000000 < 64'd16777216))
            tilt_c = 1'b0;
        else if (dot_reg < 0)
            tilt_c = 1'b1;
        else if (dot_reg == 0)
            tilt_c = (lie_cosine != 15'd0);
        else
            tilt_c = lhs < rhs;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg[0] <= accel_x; a_reg[1] <= accel_y; a_reg[2] <= accel_z;
            w_reg[0] <= gyro_x;  w_reg[1] <= gyro_y;  w_reg[2] <= gyro_z;
            key_reg  <= key_press;
        end
        if (cmd.sq)
        begin
            acc2_reg <= sq3(a_reg[0], a_reg[1], a_reg[2]);
            gyr2_reg <= sq3(w_reg[0], w_reg[1], w_reg[2]);
            lp2_reg  <= sq3(c[0], c[1], c[2]);
        end
        if (cmd.dot)
        begin
            dot_reg <= 36'(32'(c[0]) * 32'(ref_reg[0]))
                       + 36'(32'(c[1]) * 32'(ref_reg[1]))
                       + 36'(32'(c[2]) * 32'(ref_reg[2]));
            nb2_reg <= sq3(ref_reg[0], ref_reg[1], ref_reg[2]);
        end
        // squares fit 32 bits; dot square only matters when dot is positive
        if (cmd.tilt)
        begin
            sqd_reg  <= 64'(dot_reg[31:0]) * 64'(dot_reg[31:0]);
            prod_reg <= 64'(lp2_reg[31:0]) * 64'(nb2_reg[31:0]);
            cc_reg   <= 30'(lie_cosine) * 30'(lie_cosine);
        end
        if (cmd.tmul)
        begin
            rhi_reg <= 62'(cc_reg) * 62'(prod_reg[63:32]);
            rlo_reg <= 62'(cc_reg) * 62'(prod_reg[31:0]);
        end
        if (cmd.tcmp)
            tilt_reg <= tilt_c;
    end

    // phase update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_CAL;
            loaded_reg <= 1'b0;
            ccnt_reg   <= '0;
            ticks_reg  <= '0;
            still_reg  <= '0;
            imp_reg    <= 1'b0;
            rot_reg    <= 1'b0;
            rep_reg    <= 1'b0;
            fs_reg     <= PH_CAL;
            al_reg     <= 1'b0;
            rp_reg     <= 1'b0;
            cl_reg     <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                fg_reg[i]   <= '0;
                ref_reg[i]  <= '0;
                csum_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.filt)
            begin
                for (int i = 0; i < 3; i++)
                    fg_reg[i] <= fg_new[i];
                loaded_reg <= 1'b1;
            end
            if (cmd.judge)
            begin : judge_blk
                logic [2:0]  ph;
                logic [15:0] tk, st, tki;
                logic        im, ro, rp, cl, rpt;
                logic [CW-1:0] cn;
                ph = phase_reg; tk = ticks_reg; st = still_reg;
                im = imp_reg; ro = rot_reg; rp = rep_reg;
                cl = 1'b0;
                rpt = 1'b0;
                if (key_reg && (ph == PH_SUS || ph == PH_CON || ph == PH_ALM))
                begin
                    ph = PH_MON; tk = '0; st = '0;
                    im = 1'b0; ro = 1'b0; rp = 1'b0; cl = 1'b1;
                end
                tki = (tk != 16'hFFFF) ? tk + 16'd1 : tk;
                case (ph)
                    PH_CAL:
                    begin
                        if (near_g(lp2_reg, 64'd12) && gyr2_reg < 34'd589824)
                        begin
                            cn = ccnt_reg + CW'(1);
                            ccnt_reg <= cn;
                            for (int i = 0; i < 3; i++)
                                csum_reg[i] <= csum_reg[i] + 24'(c[i]);
                            if (32'(cn) >= 32'(CALIB_COUNT))
                            begin
                                for (int i = 0; i < 3; i++)
                                    ref_reg[i] <= calib_mean(csum_reg[i] + 24'(c[i]));
                                ph = PH_MON;
                            end
                        end
                        else
                        begin
                            ccnt_reg <= '0;
                            for (int i = 0; i < 3; i++)
                                csum_reg[i] <= '0;
                        end
                    end
                    PH_MON:
                    begin
                        if (acc2_reg < 34'(30'(freefall_level) * 30'(freefall_level))
                            || (acc2_reg > 34'd37748736 && gyr2_reg > 34'd40960000)
                            || gyr2_reg > 34'(30'(fast_rotate_level)
                                              * 30'(fast_rotate_level)))
                        begin
                            ph = PH_SUS; tk = '0; st = '0; im = 1'b0; ro = 1'b0;
                        end
                    end
                    PH_SUS:
                    begin
                        tk = tki;
                        if (acc2_reg > 34'(30'(impact_level) * 30'(impact_level)))
                            im = 1'b1;
                        if (gyr2_reg > 34'(30'(rotate_level) * 30'(rotate_level)))
                            ro = 1'b1;
                        if (im && ro)
                        begin
                            ph = PH_CON; tk = '0; st = '0;
                        end
                        if (tk > suspect_limit)
                            ph = PH_MON;
                    end
                    PH_CON:
                    begin
                        tk = tki;
                        if (tilt_reg && near_g(lp2_reg, 64'd18)
                            && gyr2_reg < 34'd1638400)
                        begin
                            if (st != 16'hFFFF)
                                st = st + 16'd1;
                        end
                        else if (st != 16'd0)
                            st = st - 16'd1;
                        if (st >= still_needed)
                            ph = PH_ALM;
                        if (tk > confirm_limit)
                            ph = PH_MON;
                    end
                    PH_ALM:
                    begin
                        if (!rp)
                        begin
                            rpt = 1'b1;
                            rp = 1'b1;
                        end
                    end
                    default: ph = PH_MON;
                endcase
                phase_reg <= ph; ticks_reg <= tk; still_reg <= st;
                imp_reg <= im; rot_reg <= ro; rep_reg <= rp;
                fs_reg <= ph;
                al_reg <= (ph == PH_ALM);
                rp_reg <= rpt;
                cl_reg <= cl;
            end
        end
    end
endmodule

>>> design/ifd_regs.sv
// ----------------------------------------------------------------------------
// ifd_regs: configuration register file
// APB-style write and read of the eight threshold and limit registers.
// ----------------------------------------------------------------------------
module ifd_regs
    import ifd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic [14:0] freefall_level,
    output logic [14:0] impact_level,
    output logic [14:0] rotate_level,
    output logic [14:0] fast_rotate_level,
    output logic [15:0] suspect_limit,
    output logic [15:0] confirm_limit,
    output logic [15:0] still_needed,
    output logic [14:0] lie_cosine
);
    logic [2:0] idx;
    assign idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freefall_level    <= 15'd1843;
            impact_level      <= 15'd7373;
            rotate_level      <= 15'd7680;
            fast_rotate_level <= 15'd11520;
            suspect_limit     <= 16'd50;
            confirm_limit     <= 16'd250;
            still_needed      <= 16'd50;
            lie_cosine        <= 15'd23170;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            case (idx)
                REG_FREEFALL: freefall_level    <= pwdata[14:0];
                REG_IMPACT:   impact_level      <= pwdata[14:0];
                REG_ROTATE:   rotate_level      <= pwdata[14:0];
                REG_FASTROT:  fast_rotate_level <= pwdata[14:0];
                REG_SUSLIM:   suspect_limit     <= pwdata[15:0];
                REG_CONLIM:   confirm_limit     <= pwdata[15:0];
                REG_STILL:    still_needed      <= pwdata[15:0];
                REG_LIECOS:   lie_cosine        <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_FREEFALL: prdata = 32'(freefall_level);
            REG_IMPACT:   prdata = 32'(impact_level);
            REG_ROTATE:   prdata = 32'(rotate_level);
            REG_FASTROT:  prdata = 32'(fast_rotate_level);
            REG_SUSLIM:   prdata = 32'(suspect_limit);
            REG_CONLIM:   prdata = 32'(confirm_limit);
            REG_STILL:    prdata = 32'(still_needed);
            REG_LIECOS:   prdata = 32'(lie_cosine);
            default:      prdata = '0;
        endcase
    end
endmodule

>>> design/imu_fall_detector_unit.sv
// ----------------------------------------------------------------------------
// imu_fall_detector_unit: threshold fall detector, top level
// ----------------------------------------------------------------------------
// One input word carries an accelerometer and gyroscope sample and the key
// flag; it is taken when in_valid is high and in_stall low. Each word gives
// exactly one result word (phase, alarm, report, cleared) on out_valid.
// The result word is valid once the sequencer has run filter,
// squares, dot product, three tilt steps and the phase judge in turn
// for the accepted sample. in_stall stays high meanwhile, so a new
// sample is taken only after the previous one has been judged.
// The result register holds its word while out_stall is high; the next
// sample is processed meanwhile and waits in the judge step until the
// register frees.
// Reset puts the block in calibrate, state and config registers at defaults.
// Configuration registers sit on the APB-style port, byte address 4*i.
// ----------------------------------------------------------------------------
module imu_fall_detector_unit
    import ifd_pkg::*;
#(
    parameter int CALIB_COUNT      = CALIB_COUNT_DEF,
    parameter int FILTER_FRAC_BITS = FILTER_FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    input  logic signed [15:0] gyro_z,
    input  logic               key_press,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         fall_state,
    output logic               alarm_active,
    output logic               fall_report,
    output logic               alarm_cleared
);
    logic [14:0] ff_lv, im_lv, ro_lv, fr_lv, lc;
    logic [15:0] s_lim, c_lim, st_n;
    ifd_cmd_t    cmd;

    assign pready = 1'b1;

    ifd_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .freefall_level(ff_lv), .impact_level(im_lv), .rotate_level(ro_lv),
        .fast_rotate_level(fr_lv), .suspect_limit(s_lim),
        .confirm_limit(c_lim), .still_needed(st_n), .lie_cosine(lc)
    );

    ifd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd)
    );

    ifd_datapath #(
        .CALIB_COUNT(CALIB_COUNT), .FILTER_FRAC_BITS(FILTER_FRAC_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z),
        .key_press(key_press),
        .freefall_level(ff_lv), .impact_level(im_lv), .rotate_level(ro_lv),
        .fast_rotate_level(fr_lv), .suspect_limit(s_lim),
        .confirm_limit(c_lim), .still_needed(st_n), .lie_cosine(lc),
        .fall_state(fall_state), .alarm_active(alarm_active),
        .fall_report(fall_report), .alarm_cleared(alarm_cleared)
    );
endmodule

>>> design/ifd_checker.sv
// ----------------------------------------------------------------------------
// ifd_checker: port-level checks of the fall detector
// Result consistency and handshake behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ifd_checker
    import ifd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] fall_state,
    input logic       alarm_active,
    input logic       fall_report
);
    `CHK_IMPL(a_alarm_state, clk, rst_n, out_valid, alarm_active == (fall_state == PH_ALM))
    `CHK_IMPL(a_report_alarm, clk, rst_n, out_valid && fall_report, alarm_active)
    `CHK_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(fall_state))
endmodule

bind imu_fall_detector_unit ifd_checker u_ifd_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .fall_state(fall_state),
    .alarm_active(alarm_active), .fall_report(fall_report)
);
